// ----- src/rms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS level meter package
// Shared widths, coefficients and the types that pass between the front end,
// the block queue and the back end.
// ----------------------------------------------------------------------------
package rms_pkg;

    // Samples per block before further samples of the same block are dropped.
    localparam int BLOCK_LEN = 256;

    // Sample count must hold BLOCK_LEN itself.
    localparam int CNT_W = $clog2(BLOCK_LEN + 1);

    // Square of a halved 16-bit sample is at most 2^28.
    localparam int SQ_W  = 29;
    localparam int SUM_W = SQ_W + $clog2(BLOCK_LEN);

    // Dividend of the mean square is four times the sum.
    localparam int DIV_W  = SUM_W + 2;
    localparam int STEP_W = $clog2(DIV_W);

    // Root is saturated to 16 bits, so only 32 radicand bits matter.
    localparam int ROOT_W = 16;
    localparam int RAD_W  = 2 * ROOT_W;

    // Smoothed level accumulator is Q0.24.
    localparam int ACC_W  = 24;
    localparam int LVL_W  = 16;
    localparam int KEEP_W = 16;
    localparam int NEW_W  = 13;
    localparam int PA_W   = ACC_W + KEEP_W;
    localparam int PB_W   = ROOT_W + NEW_W;
    localparam int TOT_W  = PA_W + 1;

    // 0.93 and 0.07 as fractions of 65536; they sum to exactly one.
    localparam logic [KEEP_W-1:0] COEF_KEEP = 16'd60948;
    localparam logic [NEW_W-1:0]  COEF_NEW  = 13'd4588;
    localparam logic [TOT_W-1:0]  ROUND_HALF = TOT_W'(32768);

    // Threshold register reset value.
    localparam logic [LVL_W-1:0] THR_RESET = 16'd16384;

    // Closed block handed from the front end to the back end.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } blk_t;

    // Block queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- src/rms_level_meter_with_onset.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS level meter with onset trigger
// Block RMS of a sample stream, exponential smoothing and a latched trigger.
// ----------------------------------------------------------------------------
// Samples are taken at one per cycle; the front end stalls only while two
// closed blocks wait in the queue. The back end takes a block from the
// queue, then runs 39 division steps, 16 root steps, the multiply states
// MULA and MULB and the update, which waits while an earlier result waits.
// Reset clears sums, level and trigger and sets the threshold to 1/4 scale.
module rms_level_meter_with_onset (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // block_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] smoothed_level
    output logic [1:0]  m_tuser,   // [0] above_threshold, [1] onset_pulse
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] level_threshold
);
    import rms_pkg::*;

    logic [LVL_W-1:0] thr_reg;
    logic [LVL_W-1:0] thr_next;
    q_stat_t          q_stat;
    logic             push;
    blk_t             push_data;
    logic             pop;
    blk_t             pop_data;

    // Threshold register; a write transfer is always taken.
    assign cfg_ready = 1'b1;
    assign thr_next  = (cfg_valid && cfg_ready) ? cfg_data : thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // Sample accumulation.
    rms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Closed block queue.
    rms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Per-block level computation.
    rms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // A closed block is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("block pushed into full queue");

    // The back end only takes a block that is present.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("block popped from empty queue");

    // An onset is only reported together with a set trigger.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("onset pulse without trigger");
`endif

endmodule

// ----- src/rms_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS meter front end
// Accepts samples, halves and squares them, accumulates the block sum and
// hands each closed block to the queue.
// ----------------------------------------------------------------------------
module rms_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] sample
    input  logic             s_tlast,
    input  rms_pkg::q_stat_t q_stat,
    output logic             push,
    output rms_pkg::blk_t    push_data
);
    import rms_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [15:0] half;
    logic signed [31:0] prod;
    logic [SQ_W-1:0]    sq;
    logic               room;
    logic               accept;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   count_add;

    // Halve with rounding toward minus infinity and square.
    always_comb
    begin
        half = $signed(s_tdata) >>> 1;
        prod = half * half;
        sq   = prod[SQ_W-1:0];
    end

    // Accumulate while the block still has room.
    always_comb
    begin
        room      = count_reg < CNT_W'(BLOCK_LEN);
        sum_add   = room ? sum_reg + SUM_W'(sq) : sum_reg;
        count_add = room ? count_reg + CNT_W'(1) : count_reg;
        s_tready  = !q_stat.full;
        accept    = s_tvalid && s_tready;
        push      = accept && s_tlast;
        push_data.sum   = sum_add;
        push_data.count = count_add;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_add;
            end
        end
    end

    // Running sum and sample count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/rms_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS meter block queue
// Two-entry queue of closed blocks between the front end and the back end.
// ----------------------------------------------------------------------------
module rms_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rms_pkg::blk_t    push_data,
    input  logic             pop,
    output rms_pkg::blk_t    pop_data,
    output rms_pkg::q_stat_t q_stat
);
    import rms_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    blk_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;

    // Status and pointer updates.
    always_comb
    begin
        q_stat.full  = fill_reg == (PTR_W + 1)'(DEPTH);
        q_stat.empty = fill_reg == '0;
        pop_data     = entry_reg[rd_ptr_reg];
        wr_ptr_next  = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next    = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/rms_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS meter back end
// Per block: mean square by restoring division, floor square root, the
// exponential smoother and the onset trigger, then the result register.
// ----------------------------------------------------------------------------
module rms_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      threshold,
    input  rms_pkg::q_stat_t q_stat,
    output logic             pop,
    input  rms_pkg::blk_t    pop_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [15:0] smoothed_level
    output logic [1:0]       m_tuser    // [0] above_threshold, [1] onset_pulse
);
    import rms_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_SQRT = 6'b000100,
        ST_MULA = 6'b001000,
        ST_MULB = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic                trig_reg;
    logic                trig_next;
    logic                valid_reg;
    logic                valid_next;
    logic [LVL_W-1:0]    lvl_out_reg;
    logic [LVL_W-1:0]    lvl_out_next;
    logic                pulse_out_reg;
    logic                pulse_out_next;

    logic [DIV_W-1:0]    dvd_reg;
    logic [DIV_W-1:0]    dvd_next;
    logic [CNT_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]    dvs_next;
    logic [CNT_W-1:0]    drem_reg;
    logic [CNT_W-1:0]    drem_next;
    logic [RAD_W-1:0]    rad_reg;
    logic [RAD_W-1:0]    rad_next;
    logic [ROOT_W+2:0]   srem_reg;
    logic [ROOT_W+2:0]   srem_next;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   root_next;
    logic                sat_reg;
    logic                sat_next;
    logic [PA_W-1:0]     pa_reg;
    logic [PA_W-1:0]     pa_next;
    logic [PB_W-1:0]     pb_reg;
    logic [PB_W-1:0]     pb_next;

    logic [CNT_W:0]      d_trial;
    logic                d_ge;
    logic [DIV_W-1:0]    d_shift;
    logic [ROOT_W+2:0]   s_shift;
    logic [ROOT_W+2:0]   s_trial;
    logic                s_ge;
    logic [ROOT_W-1:0]   rms;
    logic [TOT_W-1:0]    total;
    logic [ACC_W:0]      acc_wide;
    logic [ACC_W-1:0]    acc_sat;
    logic [LVL_W-1:0]    lvl;
    logic                out_free;

    // One restoring division step: one quotient bit per cycle.
    always_comb
    begin
        d_trial = {drem_reg, dvd_reg[DIV_W-1]};
        d_ge    = d_trial >= {1'b0, dvs_reg};
        d_shift = {dvd_reg[DIV_W-2:0], d_ge};
    end

    // One square root step: two radicand bits per cycle.
    always_comb
    begin
        s_shift = {srem_reg[ROOT_W:0], rad_reg[RAD_W-1:RAD_W-2]};
        s_trial = {1'b0, root_reg, 2'b01};
        s_ge    = s_shift >= s_trial;
    end

    // Smoother sum with rounding and saturation, and the result register free test.
    always_comb
    begin
        rms      = sat_reg ? '1 : root_reg;
        total    = TOT_W'(pa_reg) + TOT_W'({pb_reg, 8'd0}) + ROUND_HALF;
        acc_wide = total[TOT_W-1:16];
        acc_sat  = acc_wide[ACC_W] ? '1 : acc_wide[ACC_W-1:0];
        lvl      = acc_sat[ACC_W-1:8];
        out_free = !valid_reg || m_tready;
    end

    // Block sequencer.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        trig_next      = trig_reg;
        valid_next     = valid_reg && !m_tready;
        lvl_out_next   = lvl_out_reg;
        pulse_out_next = pulse_out_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        drem_next      = drem_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        sat_next       = sat_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop       = 1'b1;
                    step_next = '0;
                    drem_next = '0;
                    // An empty count divides zero by one, giving an RMS of zero.
                    if (pop_data.count == '0)
                    begin
                        dvd_next = '0;
                        dvs_next = CNT_W'(1);
                    end
                    else
                    begin
                        dvd_next = {pop_data.sum, 2'b00};
                        dvs_next = pop_data.count;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                drem_next = d_ge ? CNT_W'(d_trial - {1'b0, dvs_reg})
                                 : d_trial[CNT_W-1:0];
                dvd_next  = d_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    // A quotient of 2^32 or more saturates the root.
                    rad_next   = d_shift[RAD_W-1:0];
                    sat_next   = |d_shift[DIV_W-1:RAD_W];
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                srem_next = s_ge ? s_shift - s_trial : s_shift;
                root_next = {root_reg[ROOT_W-2:0], s_ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_MULA;
                end
            end
            ST_MULA:
            begin
                pa_next    = acc_reg * COEF_KEEP;
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                pb_next    = rms * COEF_NEW;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    acc_next       = acc_sat;
                    pulse_out_next = !trig_reg && (lvl > threshold);
                    if (!trig_reg && (lvl > threshold))
                    begin
                        trig_next = 1'b1;
                    end
                    else if (lvl < threshold)
                    begin
                        trig_next = 1'b0;
                    end
                    lvl_out_next = lvl;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, smoother state and trigger.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            acc_reg   <= '0;
            trig_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            trig_reg  <= trig_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath and result payload.
    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        drem_reg      <= drem_next;
        rad_reg       <= rad_next;
        srem_reg      <= srem_next;
        root_reg      <= root_next;
        sat_reg       <= sat_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        lvl_out_reg   <= lvl_out_next;
        pulse_out_reg <= pulse_out_next;
    end

    // The latched trigger after an update is the one reported with it.
    assign m_tvalid = valid_reg;
    assign m_tdata  = lvl_out_reg;
    assign m_tuser  = {pulse_out_reg, trig_reg};

endmodule

// ----- dv/rms_level_meter_with_onset_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS level meter with onset trigger testbench
// Streams blocks of audio samples into the meter and predicts each block
// result: block RMS, smoothed level and trigger state. Every result transfer
// is checked against the oldest prediction. Both stream sides idle at random,
// the receiver holds off once for a long stretch to back up the block queue,
// and the threshold is rewritten between phases while the meter is idle.
// ----------------------------------------------------------------------------
module rms_level_meter_with_onset_tb;
    import rms_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int BACKEND_LAT   = 59;
    localparam int HOLD_CYCLES   = 800;
    localparam int QUIET_LIMIT   = 4000;
    localparam int ITEM_TARGET   = 1900;
    localparam int REPORT_LIMIT  = 10;
    localparam int ACC_SAT       = 24'hFFFFFF;

    // Sample mixes used to shape a phase.
    typedef enum int {
        MIX_FULL,
        MIX_QUIET,
        MIX_EXTREME,
        MIX_LOUD,
        MIX_ANY
    } sample_mix_e;

    typedef struct {
        logic [LVL_W-1:0] level;
        logic             above;
        logic             onset;
    } meter_result_t;

    // Predicts block results and holds them until the meter delivers them.
    class level_scoreboard;
        logic [LVL_W-1:0] threshold;
        logic [36:0]      square_acc;
        int unsigned      taken;
        logic [ACC_W-1:0] level_q24;
        bit               latched;
        meter_result_t    due[$];
        int               errors;

        function new();
            threshold  = THR_RESET;
            square_acc = '0;
            taken      = 0;
            level_q24  = '0;
            latched    = 1'b0;
            errors     = 0;
        endfunction

        static function longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = r | (64'd1 << b);
                if (trial * trial <= v)
                    r = trial;
            end
            return r;
        endfunction

        function logic [LVL_W-1:0] level_now();
            return level_q24[ACC_W-1:8];
        endfunction

        function void set_threshold(logic [LVL_W-1:0] v);
            threshold = v;
        endfunction

        // Accumulates one accepted sample; a closing sample yields a result.
        function void note_sample(logic [15:0] raw, bit closing);
            longint          halved;
            longint unsigned mean_sq;
            longint unsigned root;
            longint unsigned next_acc;
            meter_result_t   r;
            halved = longint'($signed(raw)) >>> 1;
            if (taken < BLOCK_LEN)
            begin
                square_acc += 37'(halved * halved);
                taken++;
            end
            if (!closing)
                return;
            root = 0;
            if (taken != 0)
            begin
                mean_sq = square_acc;
                mean_sq = (mean_sq << 2) / taken;
                root    = int_root(mean_sq);
            end
            if (root > 64'hFFFF)
                root = 64'hFFFF;
            next_acc = level_q24;
            next_acc = (next_acc * COEF_KEEP + (root << 8) * COEF_NEW + 64'd32768) >> 16;
            if (next_acc > ACC_SAT)
                next_acc = ACC_SAT;
            level_q24 = next_acc[ACC_W-1:0];
            r.level   = level_q24[ACC_W-1:8];
            r.onset   = 1'b0;
            // Hysteresis: set above the threshold, clear below, hold on equal.
            if (!latched && r.level > threshold)
            begin
                latched = 1'b1;
                r.onset = 1'b1;
            end
            if (r.level < threshold)
                latched = 1'b0;
            r.above    = latched;
            square_acc = '0;
            taken      = 0;
            due.insert(due.size(), r);
        endfunction

        function void flag(string field, longint want, longint got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(logic [LVL_W-1:0] level, logic above, logic onset);
            meter_result_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with none expected, level %0d", $time, level);
                return;
            end
            want = due.pop_front();
            if (level !== want.level)
                flag("smoothed_level", want.level, level);
            if (above !== want.above)
                flag("above_threshold", want.above, above);
            if (onset !== want.onset)
                flag("onset_pulse", want.onset, onset);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    level_scoreboard sb;
    int  items_sent  = 0;
    int  burst_left  = 0;
    int  quiet_count = 0;
    bit  hold_req    = 1'b0;

    rms_level_meter_with_onset dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [15:0] pick_sample(sample_mix_e mix);
        int k;
        int mag;
        k = (mix == MIX_ANY) ? $urandom_range(MIX_FULL, MIX_LOUD) : int'(mix);
        case (k)
            MIX_QUIET:
                return 16'(int'($urandom_range(0, 128)) - 64);
            MIX_EXTREME:
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    3:       return 16'h0000;
                    default: return 16'h0001;
                endcase
            MIX_LOUD:
            begin
                mag = $urandom_range(20000, 32767);
                return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
            end
            default:
                return 16'($urandom);
        endcase
    endfunction

    // Mostly short blocks; a few run to and past the block length.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 24);
        if (r < 93)
            return $urandom_range(25, 200);
        if (r < 97)
            return $urandom_range(BLOCK_LEN - 6, BLOCK_LEN + 44);
        return $urandom_range(BLOCK_LEN, BLOCK_LEN + 1);
    endfunction

    // Offers one sample and waits for its transfer; idles between bursts.
    task automatic send_sample(logic [15:0] smp, bit closing);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= closing;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(smp, closing);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_block(int len, sample_mix_e mix);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(mix), i == len - 1);
    endtask

    task automatic send_fixed(logic [15:0] smp, int count);
        repeat (count) send_sample(smp, 1'b1);
    endtask

    // Waits until all results are in and the back end has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (BACKEND_LAT + 10) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_threshold(v);
        cfg_valid <= 1'b0;
    endtask

    // Result side: checks transfers and watches for a stuck run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial
    begin
        int mode;
        int span;
        int tick;
        mode = 0;
        span = 0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(20, 300);
                end
                span--;
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (tick % 5 == 0);
                endcase
            end
        end
    end

    // Stimulus.
    initial
    begin
        int               nblk;
        int               pick;
        int               t;
        sample_mix_e      mix;
        logic [LVL_W-1:0] thr;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and block lengths at the reset threshold.
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        // Full-scale blocks raise the level past the threshold, silence drops it.
        send_fixed(16'h8000, 12);
        send_fixed(16'h0000, 4);

        // Long receiver hold-off with short blocks fills the block queue.
        settle();
        write_threshold(16'd8000);
        hold_req = 1'b1;
        repeat (20) send_block($urandom_range(1, 4), MIX_LOUD);

        // Level converges; a threshold equal to it must hold the trigger.
        settle();
        write_threshold(16'hFFFF);
        send_fixed(16'h8000, 120);
        settle();
        write_threshold(sb.level_now());
        send_fixed(16'h8000, 3);
        settle();
        write_threshold(sb.level_now() - 1'b1);
        send_fixed(16'h8000, 3);
        settle();
        write_threshold(sb.level_now());
        send_fixed(16'h8000, 3);

        // Random phases, each with its own threshold and sample mix.
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                thr = '0;
            else if (pick == 1)
                thr = 16'hFFFF;
            else if (pick <= 3)
                thr = 16'($urandom);
            else
            begin
                t = int'(sb.level_now()) + int'($urandom_range(0, 1200)) - 600;
                if (t < 0)
                    t = 0;
                if (t > 65535)
                    t = 65535;
                thr = 16'(t);
            end
            write_threshold(thr);
            mix  = sample_mix_e'($urandom_range(MIX_FULL, MIX_ANY));
            nblk = $urandom_range(3, 15);
            repeat (nblk)
                if (items_sent < ITEM_TARGET)
                    send_block(pick_len(), mix);
        end

        s_tvalid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (BACKEND_LAT + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- rms_level_meter_with_onset.f -----
src/rms_pkg.sv
src/rms_front.sv
src/rms_queue.sv
src/rms_back.sv
src/rms_level_meter_with_onset.sv
dv/rms_level_meter_with_onset_tb.sv
